// ----- sv/ot_pkg.sv -----
// ---------------------------------------------------------------------------
// ot_pkg
// Shared widths, action codes and constant tables of the orientation tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package ot_pkg;

  localparam int ActionW = 3;
  localparam int AngleW  = 17;
  localparam int CoordW  = 32;

  localparam int ElementWidthDef = 32;
  localparam int SincosStepsDef  = 24;

  // action codes
  localparam logic [ActionW-1:0] ActRotX   = 3'd0;
  localparam logic [ActionW-1:0] ActRotY   = 3'd1;
  localparam logic [ActionW-1:0] ActRotZ   = 3'd2;
  localparam logic [ActionW-1:0] ActIdent  = 3'd3;
  localparam logic [ActionW-1:0] ActXfm    = 3'd4;
  localparam logic [ActionW-1:0] ActInvXfm = 3'd5;

  // CORDIC arithmetic in Q4.60, angles as binary angle (full turn = 2^32)
  localparam int CordicFrac = 60;
  localparam logic signed [63:0] CordicGain = 64'sd700114967507363231;
  localparam int AtanDepth = 32;

  localparam logic [31:0] AtanTab [AtanDepth] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000518,
    32'h0000028B, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // degrees (Q10.7) to binary angle: a * 2^22 / 45 = u * 2^22 + frac(w),
  // with a = 45 * u + w
  localparam int DegUnit   = 45;
  localparam int FracDepth = 45;
  typedef logic [21:0] frac_tab_t [FracDepth];

  function automatic frac_tab_t frac_tab_init();
    frac_tab_t tab;
    for (int w = 0; w < FracDepth; w++) begin
      tab[w] = 22'(((64'(w) << 22) + 64'd22) / DegUnit);
    end
    return tab;
  endfunction

  localparam frac_tab_t FracTab = frac_tab_init();

endpackage

`default_nettype wire

// ----- sv/ot_in_if.sv -----
// ---------------------------------------------------------------------------
// ot_in_if
// Input channel of the orientation tracker: action, angle and point.
// ---------------------------------------------------------------------------
`default_nettype none

interface ot_in_if import ot_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [ActionW-1:0]        action;
  logic signed [AngleW-1:0]  angle;
  logic signed [CoordW-1:0]  point_x;
  logic signed [CoordW-1:0]  point_y;
  logic signed [CoordW-1:0]  point_z;

  modport source (output valid, action, angle, point_x, point_y, point_z, input ready);
  modport sink   (input valid, action, angle, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ----- sv/ot_out_if.sv -----
// ---------------------------------------------------------------------------
// ot_out_if
// Result channel of the orientation tracker: transformed point.
// ---------------------------------------------------------------------------
`default_nettype none

interface ot_out_if import ot_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic                      point_valid;
  logic signed [CoordW-1:0]  out_x;
  logic signed [CoordW-1:0]  out_y;
  logic signed [CoordW-1:0]  out_z;

  modport source (output valid, point_valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, point_valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

// ----- sv/orientation_tracker_core.sv -----
// ---------------------------------------------------------------------------
// orientation_tracker_core
// Orientation matrix and its inverse with incremental axis rotations.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one item per action: rotate about x, y or z by angle
//   (degrees, Q10.7), reset to identity, or transform a Q16.16 point by the
//   orientation or its inverse. out_o returns exactly one item per input
//   item; point_valid and the coordinates are zero unless it was a transform.
//   Both matrices live in one 18-entry memory (orientation at 0..8, inverse
//   at 9..17, column-major) with a registered read; per-entry valid bits make
//   an unwritten entry read as identity, so reset and the identity action
//   take effect at once.
//   Work after accept: identity and unused actions go straight to the
//   result; transforms do three rows of 3 reads and 3 multiply-adds;
//   rotations do range reduction, CORDIC with one step per cycle, then
//   27 multiply-adds for each matrix through the single multiplier. The
//   multiplier and memory port serialise this work.
//   One item is worked on at a time; in_i.ready is high while idle. The
//   result sits in an output register, so a new item is taken while it
//   waits; if the receiver still stalls when the next result is done, the
//   block holds in its final state until the register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module orientation_tracker_core import ot_pkg::*; #(
  parameter int ELEMENT_WIDTH = ElementWidthDef,
  parameter int SINCOS_STEPS  = SincosStepsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ot_in_if.sink      in_i,
  ot_out_if.source   out_o
);

  localparam int EW    = ELEMENT_WIDTH;
  localparam int Frac  = EW - 2;
  localparam int MW    = (EW > CoordW) ? EW : CoordW;
  localparam int PW    = 2 * MW;
  localparam int AW    = PW + 2;
  localparam int Nstep = (SINCOS_STEPS < AtanDepth) ? SINCOS_STEPS : AtanDepth;
  localparam int ScSh  = CordicFrac - Frac;
  localparam int MemDepth = 18;
  localparam int AddrW = 5;

  localparam logic signed [EW-1:0] ElemOne = {2'b01, {(EW-2){1'b0}}};
  localparam logic signed [17:0] DegTurn    = 18'sd46080;
  localparam logic signed [17:0] DegHalf    = 18'sd23040;
  localparam logic signed [17:0] DegQuarter = 18'sd11520;
  localparam logic [AddrW-1:0]   InvBase    = 5'd9;

  typedef enum logic [3:0] {
    StIdle, StRed, StDiv1, StDiv2, StCord, StSc, StLoad, StMac, StWr, StFin
  } state_e;

  typedef enum logic [1:0] { PassOri, PassInv, PassXfm } pass_e;

  // control
  state_e           st_q;
  pass_e            pass_q;
  logic [1:0]       line_q, oidx_q, cnt_q, axis_q;
  logic [5:0]       step_q;
  logic [AddrW-1:0] base_q;
  logic [MemDepth-1:0] vld_q;

  // result and output registers
  logic                     res_pv_q;
  logic signed [CoordW-1:0] res_q [3];
  logic                     out_vld_q, out_pv_q;
  logic signed [CoordW-1:0] out_x_q, out_y_q, out_z_q;

  // datapath
  logic signed [AngleW-1:0] angle_q;
  logic signed [MW-1:0]     pt_q [3];
  logic [13:0]              a_mag_q;
  logic                     a_neg_q, flip_q;
  logic [8:0]               u_q;
  logic signed [63:0]       x_q, y_q;
  logic signed [31:0]       z_q;
  logic signed [EW-1:0]     s_q, c_q;
  logic signed [MW-1:0]     tmp_q [3];
  logic signed [PW-1:0]     prod_q;
  logic signed [AW-1:0]     acc_q;

  // memory
  logic signed [EW-1:0] mat_mem_q [MemDepth];
  logic signed [EW-1:0] rd_q;
  logic                 rd_vld_q, rd_diag_q;

  logic                 accept;
  logic                 mem_we;
  logic [AddrW-1:0]     raddr, waddr;
  logic signed [EW-1:0] wdata, rd_elem;

  logic signed [17:0]   red_v;
  logic                 red_flip;
  logic [28:0]          u_prod;
  logic [13:0]          w_full;
  logic [5:0]           w_idx;
  logic [30:0]          m_ang;
  logic signed [63:0]   x_sh, y_sh, x_rnd, y_rnd;
  logic signed [31:0]   atan_v;
  logic signed [EW-1:0] c_new, s_new;
  logic signed [MW-1:0] opa, opb;
  logic signed [AW-1:0] rsum, rsh;
  logic signed [EW-1:0] sat_e;
  logic signed [CoordW-1:0] sat_p;
  logic                 last_o;

  assign accept       = in_i.valid && in_i.ready;
  assign in_i.ready   = (st_q == StIdle);
  assign out_o.valid  = out_vld_q;
  assign out_o.point_valid = out_pv_q;
  assign out_o.out_x  = out_x_q;
  assign out_o.out_y  = out_y_q;
  assign out_o.out_z  = out_z_q;

  // element (row, col) of the rotation about the given axis
  function automatic logic signed [EW-1:0] rcoef(
    input logic [1:0] axis, input logic [1:0] row, input logic [1:0] col,
    input logic signed [EW-1:0] s, input logic signed [EW-1:0] c);
    logic signed [EW-1:0] v;
    v = '0;
    case (axis)
      2'd0: begin
        if (row == 2'd0 && col == 2'd0) v = ElemOne;
        if (row == 2'd1 && col == 2'd1) v = c;
        if (row == 2'd2 && col == 2'd2) v = c;
        if (row == 2'd2 && col == 2'd1) v = s;
        if (row == 2'd1 && col == 2'd2) v = -s;
      end
      2'd1: begin
        if (row == 2'd0 && col == 2'd0) v = c;
        if (row == 2'd1 && col == 2'd1) v = ElemOne;
        if (row == 2'd2 && col == 2'd2) v = c;
        if (row == 2'd2 && col == 2'd0) v = -s;
        if (row == 2'd0 && col == 2'd2) v = s;
      end
      default: begin
        if (row == 2'd0 && col == 2'd0) v = c;
        if (row == 2'd1 && col == 2'd1) v = c;
        if (row == 2'd2 && col == 2'd2) v = ElemOne;
        if (row == 2'd1 && col == 2'd0) v = s;
        if (row == 2'd0 && col == 2'd1) v = -s;
      end
    endcase
    return v;
  endfunction

  function automatic logic is_diag(input logic [AddrW-1:0] a);
    return (a == 5'd0) || (a == 5'd4) || (a == 5'd8) ||
           (a == 5'd9) || (a == 5'd13) || (a == 5'd17);
  endfunction

  // angle reduction into [-90, 90] degrees with sign flip
  always_comb begin
    red_v = {angle_q[AngleW-1], angle_q};
    red_flip = 1'b0;
    if (red_v < 0) red_v = red_v + DegTurn;
    if (red_v < 0) red_v = red_v + DegTurn;
    if (red_v >= DegTurn) red_v = red_v - DegTurn;
    if (red_v >= DegHalf) red_v = red_v - DegTurn;
    if (red_v > DegQuarter) begin
      red_v = red_v - DegHalf;
      red_flip = 1'b1;
    end
    if (red_v < -DegQuarter) begin
      red_v = red_v + DegHalf;
      red_flip = 1'b1;
    end
  end

  // degrees to binary angle: quotient by reciprocal, remainder by table
  assign u_prod = 29'(a_mag_q) * 29'd23302;
  assign w_full = a_mag_q - 14'(u_q * 14'd45);
  assign w_idx  = w_full[5:0];
  assign m_ang  = {u_q, FracTab[w_idx]};

  // CORDIC step
  assign x_sh   = x_q >>> step_q[4:0];
  assign y_sh   = y_q >>> step_q[4:0];
  assign atan_v = AtanTab[step_q[4:0]];
  assign x_rnd  = (x_q + (64'sd1 <<< (ScSh - 1))) >>> ScSh;
  assign y_rnd  = (y_q + (64'sd1 <<< (ScSh - 1))) >>> ScSh;
  assign c_new  = flip_q ? -EW'(x_rnd) : EW'(x_rnd);
  assign s_new  = flip_q ? -EW'(y_rnd) : EW'(y_rnd);

  // memory addressing: ORI works a row, INV a column, XFM a row
  always_comb begin
    case (pass_q)
      PassInv: raddr = base_q + 5'({line_q, 1'b0}) + 5'(line_q) + 5'(cnt_q);
      default: raddr = base_q + 5'({cnt_q, 1'b0}) + 5'(cnt_q) + 5'(line_q);
    endcase
    case (pass_q)
      PassInv: waddr = base_q + 5'({line_q, 1'b0}) + 5'(line_q) + 5'(oidx_q);
      default: waddr = 5'({oidx_q, 1'b0}) + 5'(oidx_q) + 5'(line_q);
    endcase
  end

  assign rd_elem = rd_vld_q ? rd_q : (rd_diag_q ? ElemOne : '0);

  // multiply-add operands
  assign opa = tmp_q[cnt_q];
  assign opb = (pass_q == PassXfm) ? pt_q[cnt_q]
             : MW'(rcoef(axis_q, cnt_q, oidx_q, s_q, c_q));

  // round, shift and saturate the sum of three products
  assign rsum = acc_q + (AW'(1) <<< (Frac - 1));
  assign rsh  = rsum >>> Frac;
  always_comb begin
    if ((&rsh[AW-1:EW-1]) || !(|rsh[AW-1:EW-1])) sat_e = rsh[EW-1:0];
    else sat_e = rsh[AW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    if ((&rsh[AW-1:CoordW-1]) || !(|rsh[AW-1:CoordW-1])) sat_p = rsh[CoordW-1:0];
    else sat_p = rsh[AW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
  end

  assign mem_we = (st_q == StWr) && (pass_q != PassXfm);
  assign wdata  = sat_e;
  assign last_o = (pass_q == PassXfm) || (oidx_q == 2'd2);

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      pass_q    <= PassOri;
      line_q    <= '0;
      oidx_q    <= '0;
      cnt_q     <= '0;
      axis_q    <= '0;
      step_q    <= '0;
      base_q    <= '0;
      vld_q     <= '0;
      res_pv_q  <= 1'b0;
      res_q[0]  <= '0;
      res_q[1]  <= '0;
      res_q[2]  <= '0;
      out_vld_q <= 1'b0;
      out_pv_q  <= 1'b0;
      out_x_q   <= '0;
      out_y_q   <= '0;
      out_z_q   <= '0;
    end else begin
      // drop the taken result unless the final state refills the register
      if (out_vld_q && out_o.ready && st_q != StFin) out_vld_q <= 1'b0;
      if (mem_we) vld_q[waddr] <= 1'b1;
      case (st_q)
        StIdle: if (in_i.valid) begin
          res_pv_q <= 1'b0;
          res_q[0] <= '0;
          res_q[1] <= '0;
          res_q[2] <= '0;
          axis_q   <= in_i.action[1:0];
          line_q   <= '0;
          cnt_q    <= '0;
          if (in_i.action == ActRotX || in_i.action == ActRotY ||
              in_i.action == ActRotZ) begin
            st_q <= StRed;
          end else if (in_i.action == ActIdent) begin
            vld_q <= '0;
            st_q  <= StFin;
          end else if (in_i.action == ActXfm || in_i.action == ActInvXfm) begin
            pass_q   <= PassXfm;
            base_q   <= (in_i.action == ActInvXfm) ? InvBase : '0;
            res_pv_q <= 1'b1;
            st_q     <= StLoad;
          end else begin
            st_q <= StFin;
          end
        end
        StRed:  st_q <= StDiv1;
        StDiv1: st_q <= StDiv2;
        StDiv2: begin
          step_q <= '0;
          st_q   <= StCord;
        end
        StCord: begin
          if (step_q == 6'(Nstep)) st_q <= StSc;
          else step_q <= step_q + 6'd1;
        end
        StSc: begin
          pass_q <= PassOri;
          base_q <= '0;
          line_q <= '0;
          cnt_q  <= '0;
          st_q   <= StLoad;
        end
        StLoad: begin
          if (cnt_q == 2'd3) begin
            cnt_q  <= '0;
            oidx_q <= '0;
            st_q   <= StMac;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        StMac: begin
          if (cnt_q == 2'd3) begin
            cnt_q <= '0;
            st_q  <= StWr;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        StWr: begin
          if (pass_q == PassXfm) res_q[line_q] <= sat_p;
          if (!last_o) begin
            oidx_q <= oidx_q + 2'd1;
            st_q   <= StMac;
          end else if (line_q != 2'd2) begin
            line_q <= line_q + 2'd1;
            st_q   <= StLoad;
          end else if (pass_q == PassOri) begin
            pass_q <= PassInv;
            base_q <= InvBase;
            line_q <= '0;
            st_q   <= StLoad;
          end else begin
            st_q <= StFin;
          end
        end
        StFin: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q <= 1'b1;
            out_pv_q  <= res_pv_q;
            out_x_q   <= res_q[0];
            out_y_q   <= res_q[1];
            out_z_q   <= res_q[2];
            st_q      <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      angle_q <= in_i.angle;
      pt_q[0] <= MW'(in_i.point_x);
      pt_q[1] <= MW'(in_i.point_y);
      pt_q[2] <= MW'(in_i.point_z);
    end
    case (st_q)
      StRed: begin
        a_neg_q <= red_v[17];
        a_mag_q <= red_v[17] ? 14'(-red_v) : 14'(red_v);
        flip_q  <= red_flip;
      end
      StDiv1: u_q <= u_prod[28:20];
      StDiv2: begin
        z_q <= a_neg_q ? -$signed({1'b0, m_ang}) : $signed({1'b0, m_ang});
        x_q <= CordicGain;
        y_q <= '0;
      end
      StCord: if (step_q < 6'(Nstep)) begin
        if (!z_q[31]) begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + atan_v;
        end
      end
      StSc: begin
        c_q <= c_new;
        s_q <= s_new;
      end
      StLoad: if (cnt_q != 2'd0) tmp_q[2'(cnt_q - 2'd1)] <= MW'(rd_elem);
      StMac: begin
        if (cnt_q != 2'd3) prod_q <= opa * opb;
        if (cnt_q != 2'd0) acc_q <= ((cnt_q == 2'd1) ? AW'(0) : acc_q) + AW'(prod_q);
      end
      default: ;
    endcase
    rd_vld_q  <= vld_q[raddr];
    rd_diag_q <= is_diag(raddr);
  end

  // matrix memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mat_mem_q[waddr] <= wdata;
    rd_q <= mat_mem_q[raddr];
  end

  // identity clears every per-entry valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.action == ActIdent) |=> (vld_q == '0))
    else $error("identity did not clear the matrices");

  // the memory is written only while updating a matrix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (st_q == StWr && (pass_q == PassOri || pass_q == PassInv)))
    else $error("matrix write outside an update");

  // CORDIC never runs past its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StCord) |-> (step_q <= 6'(Nstep)))
    else $error("CORDIC step count overrun");

  // a finished result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StFin && out_vld_q && !out_o.ready) |=> (st_q == StFin))
    else $error("result dropped while receiver stalled");

endmodule

`default_nettype wire

// ----- verif/ot_scoreboard.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ot_scoreboard
// Predicts orientation tracker results and checks them in arrival order.
// ---------------------------------------------------------------------------

class ot_scoreboard;
  typedef struct packed {
    logic        point_valid;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_res_t;

  localparam int Frac = 30;

  logic signed [63:0] orient [9];
  logic signed [63:0] inv_orient [9];
  point_res_t         pending_points [$];
  int                 mismatches;

  function new();
    mismatches = 0;
    load_identity();
  endfunction

  function void load_identity();
    for (int i = 0; i < 9; i++) begin
      orient[i]     = (i % 4 == 0) ? (64'sd1 <<< Frac) : 64'sd0;
      inv_orient[i] = orient[i];
    end
  endfunction

  // exact three-term dot product, round half up, floor shift, saturate
  function logic signed [63:0] dot_round(logic signed [63:0] a0, logic signed [63:0] a1,
                                         logic signed [63:0] a2, logic signed [63:0] b0,
                                         logic signed [63:0] b1, logic signed [63:0] b2,
                                         int width);
    logic signed [129:0] acc;
    logic signed [129:0] lim;
    acc = 130'(a0) * 130'(b0) + 130'(a1) * 130'(b1) + 130'(a2) * 130'(b2);
    acc = (acc + (130'sd1 <<< (Frac - 1))) >>> Frac;
    lim = 130'sd1 <<< (width - 1);
    if (acc < -lim) return 64'(-lim);
    if (acc > lim - 1) return 64'(lim - 1);
    return 64'(acc);
  endfunction

  function void sine_cosine(logic signed [16:0] angle, output logic signed [63:0] s,
                            output logic signed [63:0] c);
    int a;
    bit flip;
    logic [63:0] m;
    logic signed [63:0] x, y, z, t;
    a = angle % 46080;
    flip = 0;
    if (a < 0) a += 46080;
    if (a >= 23040) a -= 46080;
    if (a > 11520) begin a -= 23040; flip = 1; end
    if (a < -11520) begin a += 23040; flip = 1; end
    m = ((64'(a < 0 ? -a : a) << 22) + 64'd22) / 64'd45;
    z = (a < 0) ? -$signed(m) : $signed(m);
    x = ot_pkg::CordicGain;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); z = z - $signed({32'd0, ot_pkg::AtanTab[i]});
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); z = z + $signed({32'd0, ot_pkg::AtanTab[i]});
      end
      x = t;
    end
    x = (x + (64'sd1 <<< 29)) >>> 30;
    y = (y + (64'sd1 <<< 29)) >>> 30;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function void rotate(int axis, logic signed [16:0] angle);
    logic signed [63:0] s, c, one;
    logic signed [63:0] r [9];
    logic signed [63:0] rt [9];
    logic signed [63:0] t1 [9];
    logic signed [63:0] t2 [9];
    sine_cosine(angle, s, c);
    one = 64'sd1 <<< Frac;
    for (int i = 0; i < 9; i++) r[i] = 0;
    case (axis)
      0: begin r[0] = one; r[4] = c; r[5] = s; r[7] = -s; r[8] = c; end
      1: begin r[0] = c; r[2] = -s; r[4] = one; r[6] = s; r[8] = c; end
      default: begin r[0] = c; r[1] = s; r[3] = -s; r[4] = c; r[8] = one; end
    endcase
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++) rt[j*3+i] = r[i*3+j];
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++) begin
        t1[j*3+i] = dot_round(orient[i], orient[3+i], orient[6+i],
                              r[j*3], r[j*3+1], r[j*3+2], 32);
        t2[j*3+i] = dot_round(rt[i], rt[3+i], rt[6+i],
                              inv_orient[j*3], inv_orient[j*3+1], inv_orient[j*3+2], 32);
      end
    orient = t1;
    inv_orient = t2;
  endfunction

  function void note_action(logic [2:0] action, logic signed [16:0] angle,
                            logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
    point_res_t res;
    res = '0;
    case (action)
      ot_pkg::ActRotX, ot_pkg::ActRotY, ot_pkg::ActRotZ: rotate(int'(action), angle);
      ot_pkg::ActIdent: load_identity();
      ot_pkg::ActXfm, ot_pkg::ActInvXfm: begin
        res.point_valid = 1'b1;
        if (action == ot_pkg::ActXfm) begin
          res.x = 32'(dot_round(orient[0], orient[3], orient[6], px, py, pz, 32));
          res.y = 32'(dot_round(orient[1], orient[4], orient[7], px, py, pz, 32));
          res.z = 32'(dot_round(orient[2], orient[5], orient[8], px, py, pz, 32));
        end else begin
          res.x = 32'(dot_round(inv_orient[0], inv_orient[3], inv_orient[6], px, py, pz, 32));
          res.y = 32'(dot_round(inv_orient[1], inv_orient[4], inv_orient[7], px, py, pz, 32));
          res.z = 32'(dot_round(inv_orient[2], inv_orient[5], inv_orient[8], px, py, pz, 32));
        end
      end
      default: ;
    endcase
    pending_points.push_back(res);
  endfunction

  function void check_point(point_res_t got);
    point_res_t exp;
    if (pending_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending_points.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp pv=%0b x=%h y=%h z=%h got pv=%0b x=%h y=%h z=%h",
                 exp.point_valid, exp.x, exp.y, exp.z,
                 got.point_valid, got.x, got.y, got.z);
    end
  endfunction
endclass

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives rotations, identity, transforms and unused codes into the tracker
// under varied idling and checks every result against a local predictor.
// ---------------------------------------------------------------------------

module testbench;
  import ot_pkg::*;

  logic clk_i;
  logic rst_ni;

  ot_in_if  in_ch ();
  ot_out_if out_ch ();

  orientation_tracker_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  ot_scoreboard points_sb;
  int  send_idle_pct;    // chance in percent that the sender idles a cycle
  int  recv_stall_pct;   // chance in percent that the receiver stalls a cycle
  int  hold_off_len;     // length of the long receiver hold-off
  int  hold_off_cnt;     // hold-off cycles already spent, counted by the receiver
  longint cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample results at the rising edge; compare each against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      points_sb.check_point({out_ch.point_valid, out_ch.out_x, out_ch.out_y, out_ch.out_z});
  end

  // Receiver: stall randomly, or hold off completely while a pressure stretch runs.
  always @(negedge clk_i) begin
    if (hold_off_cnt < hold_off_len) begin
      hold_off_cnt <= hold_off_cnt + 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Bound the run; receiver stalls lengthen it.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("orientation_tracker_core verification failed");
      $finish;
    end
  end

  // Offer one item and hold it until accepted; idle gaps come first.
  task automatic send_action(logic [2:0] action, logic signed [16:0] angle,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= action;
    in_ch.angle   <= angle;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    do @(posedge clk_i); while (!in_ch.ready);
    points_sb.note_action(action, angle, px, py, pz);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $signed($urandom());
      1: return $signed($urandom_range(32'h000FFFFF)) - 32'sh00080000;
      2: return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(32'h03FFFFFF)) - 32'sh02000000;
    endcase
  endfunction

  function automatic logic signed [16:0] rand_angle();
    if ($urandom_range(3) == 0) return 17'($urandom());
    return 17'($signed($urandom_range(92160)) - 46080);
  endfunction

  // Random item mix: mostly rotations and transforms, sometimes identity or unused codes.
  task automatic send_random();
    int pick;
    logic [2:0] action;
    pick = $urandom_range(99);
    if (pick < 45)      action = 3'($urandom_range(2));
    else if (pick < 88) action = ($urandom_range(1)) ? ActXfm : ActInvXfm;
    else if (pick < 95) action = ActIdent;
    else                action = 3'($urandom_range(7, 6));
    send_action(action, rand_angle(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Drop valid, then wait until every predicted result has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (points_sb.pending_points.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  initial begin
    points_sb       = new();
    rst_ni          = 1'b0;
    cycle_count     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_len    = 0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ActIdent;
    in_ch.angle     = '0;
    in_ch.point_x   = '0;
    in_ch.point_y   = '0;
    in_ch.point_z   = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: transforms at identity, angle extremes, each axis, unused codes.
    send_action(ActXfm, 17'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000);
    send_action(ActInvXfm, 17'sd0, 32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF);
    send_action(ActRotX, 17'sd11520, '0, '0, '0);
    send_action(ActRotY, -17'sd46080, '0, '0, '0);
    send_action(ActRotZ, 17'sd46080, '0, '0, '0);
    send_action(ActRotX, 17'sh0FFFF, '0, '0, '0);
    send_action(ActRotY, 17'sh10000, '0, '0, '0);
    send_action(ActRotZ, 17'sd23040, '0, '0, '0);
    send_action(ActRotX, -17'sd11521, '0, '0, '0);
    send_action(ActRotZ, 17'sd5760, '0, '0, '0);
    send_action(ActXfm, 17'sh1FFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_action(ActInvXfm, 17'sh1FFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_action(ActXfm, '0, 32'sh00012345, -32'sh00054321, 32'sh00100000);
    send_action(3'd6, 17'sd100, 32'sh1, 32'sh2, 32'sh3);
    send_action(3'd7, -17'sd1, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF);
    send_action(ActInvXfm, '0, 32'sh00012345, -32'sh00054321, 32'sh00100000);
    send_action(ActIdent, '0, '0, '0, '0);
    send_action(ActXfm, '0, 32'sh00030000, 32'sh00050000, -32'sh00070000);
    wait_drained();

    // Pressure: stall the receiver long while the sender keeps offering items.
    hold_off_len = 800;
    for (int i = 0; i < 20; i++) send_random();
    wait_drained();

    // Random phases across idling mixes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int i = 0; i < 400; i++) send_random();
      wait_drained();
    end

    if (points_sb.mismatches == 0 && points_sb.pending_points.size() == 0) begin
      $display("orientation_tracker_core verification clean");
    end else begin
      $display("orientation_tracker_core verification failed");
    end
    $finish;
  end
endmodule
